>>> sv/brm_pkg.sv
// brm_pkg: shared constants, types and the power-of-ten rom for the rate meter
// no dependencies
package brm_pkg;
	localparam int CHANNELS_DEF = 3;
	localparam int TOP_SCALE_DEF = 116;
	localparam logic [6:0] RESET_INDEX = 7'd50;
	localparam logic [23:0] RESET_WINDOW = 24'd1000000;
	localparam logic [5:0] RESET_SHRINK = 6'd20;
	localparam logic [39:0] RATE_MAX = {40{1'b1}};
	localparam logic [30:0] FIVE_POW_13 = 31'd1220703125;
	localparam logic CFG_WINDOW = 1'b0;
	localparam logic CFG_SHRINK = 1'b1;
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_FRAME = 1'b1;

	typedef struct packed {
		logic [63:0] num;
		logic [39:0] den;
		logic        start;
	} div_req_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic div_start;
		logic div_sel;
		logic mul_go;
		logic cmp_go;
		logic commit;
	} brm_cmd_t;

	typedef struct packed {
		logic div_done;
		logic is_frame;
		logic skip;
		logic direct;
	} brm_sts_t;

	function automatic logic [46:0] pow10(input logic [3:0] d);
		logic [46:0] r;
		r = 47'd1;
		case (d)
			4'd0: r = 47'd1;
			4'd1: r = 47'd10;
			4'd2: r = 47'd100;
			4'd3: r = 47'd1000;
			4'd4: r = 47'd10000;
			4'd5: r = 47'd100000;
			4'd6: r = 47'd1000000;
			4'd7: r = 47'd10000000;
			4'd8: r = 47'd100000000;
			4'd9: r = 47'd1000000000;
			4'd10: r = 47'd10000000000;
			4'd11: r = 47'd100000000000;
			4'd12: r = 47'd1000000000000;
			4'd13: r = 47'd10000000000000;
			default: r = 47'd100000000000000;
		endcase
		return r;
	endfunction

	// index / 9 by reciprocal multiply, exact for every 7-bit index
	function automatic logic [3:0] idx_decade(input logic [6:0] i);
		logic [12:0] p;
		p = 13'(i) * 13'd57;
		return p[12:9];
	endfunction

	// index mod 9 plus two
	function automatic logic [3:0] idx_steps(input logic [6:0] i);
		logic [6:0] q9;
		q9 = {3'd0, idx_decade(i)} * 7'd9;
		return 4'(i - q9) + 4'd2;
	endfunction
endpackage

>>> sv/brm_if.sv
// brm_if: valid/ready channels for items, results and configuration writes
// uses brm_pkg only through its users
interface brm_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [2:0]  channel;
	logic        direction;
	logic [23:0] byte_count;
	logic [23:0] elapsed_us;
	modport source(output valid, command, channel, direction, byte_count, elapsed_us,
		input ready);
	modport sink(input valid, command, channel, direction, byte_count, elapsed_us,
		output ready);
endinterface

interface brm_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [39:0] stream_rate;
	logic [43:0] total_in;
	logic [43:0] total_out;
	logic [6:0]  scale_index;
	logic [3:0]  scale_steps;
	logic [3:0]  scale_decade;
	modport source(output valid, kind, stream_rate, total_in, total_out, scale_index,
		scale_steps, scale_decade, input ready);
	modport sink(input valid, kind, stream_rate, total_in, total_out, scale_index,
		scale_steps, scale_decade, output ready);
endinterface

interface brm_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [23:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> sv/bandwidth_rate_meter_autorange_core.sv
// per-stream rate meter with autoranging display scale
// sequence: a frame or ignored sample goes through decode, commit and show; a sample at
// or past the window adds one 64-step divide, and one inside it two (target, then step)
// flow: one item at a time, the next word taken only after the result is accepted
// reset: rates and sums zero, index 50 (capped), registers to defaults; no clearing pass
module bandwidth_rate_meter_autorange_core #(
	parameter int CHANNELS = brm_pkg::CHANNELS_DEF,
	parameter int TOP_SCALE_INDEX = brm_pkg::TOP_SCALE_DEF
) (
	input logic clk,
	input logic arst_n,
	brm_in_if.sink   in_ch,
	brm_out_if.source out_ch,
	brm_cfg_if.sink  cfg
);
	brm_pkg::brm_cmd_t cmd;
	brm_pkg::brm_sts_t sts;
	logic [6:0] idx;

	assign cfg.ready = 1'b1;

	brm_ctrl u_ctrl (.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .cmd, .sts);

	brm_datapath #(.CHANNELS(CHANNELS), .TOP_SCALE_INDEX(TOP_SCALE_INDEX)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.in_command(in_ch.command), .in_channel(in_ch.channel),
		.in_direction(in_ch.direction), .in_bytes(in_ch.byte_count),
		.in_elapsed(in_ch.elapsed_us),
		.cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
		.res_kind(out_ch.kind), .res_rate(out_ch.stream_rate),
		.res_in(out_ch.total_in), .res_out(out_ch.total_out), .res_index(idx));

	assign out_ch.scale_index = idx;
	assign out_ch.scale_steps = brm_pkg::idx_steps(idx);
	assign out_ch.scale_decade = brm_pkg::idx_decade(idx);
endmodule

>>> sv/brm_div.sv
// brm_div: radix-2 restoring divider, 64-bit dividend by 40-bit divisor
// depends on brm_pkg
module brm_div (
	input  logic                clk,
	input  logic                arst_n,
	input  brm_pkg::div_req_t   req,
	output logic                done,
	output logic [63:0]         quot
);
	logic [63:0] q_q;
	logic [40:0] rem_q;
	logic [39:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [40:0] trial;
	logic [41:0] diff;

	assign trial = {rem_q[39:0], q_q[63]};
	assign diff = {1'b0, trial} - {2'b0, den_q};
	assign quot = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[41]) begin
				rem_q <= diff[40:0];
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end
endmodule

>>> sv/brm_datapath.sv
// brm_datapath: rate store, sums, autorange registers and arithmetic
// depends on brm_pkg and brm_div
module brm_datapath #(
	parameter int CHANNELS = brm_pkg::CHANNELS_DEF,
	parameter int TOP_SCALE_INDEX = brm_pkg::TOP_SCALE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  brm_pkg::brm_cmd_t cmd,
	output brm_pkg::brm_sts_t sts,
	input  logic              in_command,
	input  logic [2:0]        in_channel,
	input  logic              in_direction,
	input  logic [23:0]       in_bytes,
	input  logic [23:0]       in_elapsed,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_index,
	input  logic [23:0]       cfg_data,
	output logic              res_kind,
	output logic [39:0]       res_rate,
	output logic [43:0]       res_in,
	output logic [43:0]       res_out,
	output logic [6:0]        res_index
);
	localparam int SLOTS = 2 * CHANNELS;
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [6:0] TOP = 7'(TOP_SCALE_INDEX);
	localparam logic [6:0] RST_IDX = (brm_pkg::RESET_INDEX < TOP) ? brm_pkg::RESET_INDEX : TOP;

	logic [39:0] rates_q [SLOTS];
	logic [43:0] sum_in_q, sum_out_q;
	logic [6:0]  index_q;
	logic signed [6:0] cdown_q;
	logic [23:0] window_q;
	logic [5:0]  shrink_q;

	logic        cmd_q, dir_q, valid_ch_q;
	logic [SW-1:0] slot_q;
	logic [23:0] el_q, bytes_q;
	logic [39:0] old_q, target_q, upd_q;
	logic        up_q;
	logic [77:0] lo_q, hi_q, ref_q;

	brm_pkg::div_req_t req;
	logic        div_done;
	logic [63:0] div_q;
	logic [39:0] delta, tgt_sat;
	logic [43:0] total;
	logic [3:0]  decade, dec_c;
	logic [3:0]  steps;

	assign total = (sum_in_q > sum_out_q) ? sum_in_q : sum_out_q;
	assign decade = brm_pkg::idx_decade(index_q);
	assign steps = brm_pkg::idx_steps(index_q);
	assign dec_c = (decade > 4'd14) ? 4'd14 : decade;
	assign tgt_sat = (div_q > {24'd0, brm_pkg::RATE_MAX}) ? brm_pkg::RATE_MAX : div_q[39:0];
	assign delta = up_q ? (target_q - old_q) : (old_q - target_q);

	// first division: target rate, second: step = |delta|*elapsed/window
	always_comb begin
		req.start = cmd.div_start;
		if (!cmd.div_sel) begin
			req.num = {14'd0, 34'(bytes_q) * 34'd1000, 16'd0};
			req.den = {16'd0, el_q};
		end else begin
			req.num = {24'd0, delta} * {40'd0, el_q};
			req.den = {16'd0, window_q};
		end
	end

	brm_div u_div (.clk, .arst_n, .req, .done(div_done), .quot(div_q));

	assign sts.div_done = div_done;
	assign sts.is_frame = cmd_q;
	assign sts.skip = !valid_ch_q || el_q == 24'd0;
	assign sts.direct = el_q >= window_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) rates_q[i] <= '0;
			sum_in_q <= '0;
			sum_out_q <= '0;
			index_q <= RST_IDX;
			cdown_q <= '0;
			window_q <= brm_pkg::RESET_WINDOW;
			shrink_q <= brm_pkg::RESET_SHRINK;
		end else begin
			if (cfg_we) begin
				if (cfg_index == brm_pkg::CFG_WINDOW) window_q <= cfg_data;
				else shrink_q <= cfg_data[5:0];
			end
			if (cmd.commit) begin
				if (cmd_q) begin
					if (hi_q < ref_q) begin
						if (cdown_q > -7'sd1) cdown_q <= cdown_q - 7'sd1;
						if ((cdown_q - 7'sd1) < 7'sd0 && index_q > 7'd0)
							index_q <= index_q - 7'd1;
					end else begin
						cdown_q <= signed'({1'b0, shrink_q});
						if (lo_q > ref_q && index_q < TOP) index_q <= index_q + 7'd1;
					end
				end else if (!sts.skip) begin
					rates_q[slot_q] <= upd_q;
					if (!dir_q) sum_in_q <= sum_in_q - {4'd0, old_q} + {4'd0, upd_q};
					else sum_out_q <= sum_out_q - {4'd0, old_q} + {4'd0, upd_q};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_command;
			dir_q <= in_direction;
			valid_ch_q <= {29'd0, in_channel} < CHANNELS;
			slot_q <= SW'((in_direction ? 4'(CHANNELS) : 4'd0) + {1'b0, in_channel});
			el_q <= in_elapsed;
			bytes_q <= in_bytes;
		end
		if (cmd.mul_go) begin
			old_q <= rates_q[slot_q];
			target_q <= tgt_sat;
			up_q <= tgt_sat >= rates_q[slot_q];
			upd_q <= tgt_sat;
		end
		if (cmd.cmp_go) begin
			lo_q <= 78'(total) * 78'(brm_pkg::FIVE_POW_13);
			hi_q <= 78'({total, 1'b0}) * 78'(brm_pkg::FIVE_POW_13);
			ref_q <= 78'(48'(steps) * {1'b0, brm_pkg::pow10(dec_c)}) << 23;
		end
		if (div_done && cmd.div_sel)
			upd_q <= up_q ? old_q + div_q[39:0] : old_q - div_q[39:0];
	end

	assign res_kind = cmd_q;
	assign res_rate = cmd_q ? 40'd0 : (!valid_ch_q ? 40'd0 : rates_q[slot_q]);
	assign res_in = sum_in_q;
	assign res_out = sum_out_q;
	assign res_index = index_q;
endmodule

>>> sv/brm_ctrl.sv
// brm_ctrl: sequencer for one item at a time through the datapath
// depends on brm_pkg
module brm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output brm_pkg::brm_cmd_t cmd,
	input  brm_pkg::brm_sts_t sts
);
	typedef enum logic [2:0] {IDLE, DECODE, DIV1, MUL, DIV2, CMP, COMMIT, SHOW} state_t;
	state_t state_q;
	logic   sel_q;

	assign in_ready = state_q == IDLE && !out_valid;

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		cmd.div_sel = sel_q;
		cmd.div_start = (state_q == DECODE && !sts.is_frame && !sts.skip)
			|| (state_q == MUL && !sts.direct);
		if (state_q == MUL) cmd.div_sel = 1'b1;
		cmd.mul_go = state_q == DIV1 && sts.div_done;
		cmd.cmp_go = state_q == DECODE || (state_q == DIV1 && sts.div_done);
		cmd.commit = state_q == COMMIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			out_valid <= 1'b0;
			sel_q <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				IDLE: if (cmd.load) state_q <= DECODE;
				DECODE: begin
					sel_q <= 1'b0;
					state_q <= (sts.is_frame || sts.skip) ? COMMIT : DIV1;
				end
				DIV1: if (sts.div_done) state_q <= MUL;
				MUL: begin
					sel_q <= 1'b1;
					state_q <= sts.direct ? COMMIT : DIV2;
				end
				DIV2: if (sts.div_done) state_q <= COMMIT;
				COMMIT: state_q <= SHOW;
				SHOW: begin
					out_valid <= 1'b1;
					sel_q <= 1'b0;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

>>> sv/brm_checker.sv
// brm_checker: port-level assertions on the rate meter, bound to the top level
// depends on the top level's ports only
module brm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       kind,
	input logic [39:0] stream_rate,
	input logic [6:0] scale_index
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(scale_index)) else $error("hold");
	a_frame_rate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind |-> stream_rate == 40'd0) else $error("frame rate");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("overlap");
	// the index moves by at most one step at a time
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		scale_index != $past(scale_index) |-> scale_index - $past(scale_index) + 7'd1 <= 7'd2)
		else $error("step");
endmodule

bind bandwidth_rate_meter_autorange_core brm_checker u_chk (.clk, .arst_n,
	.in_valid(in_ch.valid), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
	.out_ready(out_ch.ready), .kind(out_ch.kind), .stream_rate(out_ch.stream_rate),
	.scale_index(out_ch.scale_index));

>>> sim/bandwidth_rate_meter_autorange_core_tb.sv
// testbench for bandwidth_rate_meter_autorange_core: drives samples and frame ticks,
// predicts each answer from its own copy of the meter state and checks every field
// depends on brm_pkg and the channel interfaces in brm_if
`timescale 1ns / 100ps
module bandwidth_rate_meter_autorange_core_tb;
	localparam int NCH = 3;
	localparam int TOP_IDX = 116;
	localparam longint unsigned CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic        command;
		logic [2:0]  channel;
		logic        direction;
		logic [23:0] byte_count;
		logic [23:0] elapsed_us;
	} meter_item_t;

	typedef struct packed {
		logic        kind;
		logic [39:0] stream_rate;
		logic [43:0] total_in;
		logic [43:0] total_out;
		logic [6:0]  scale_index;
		logic [3:0]  scale_steps;
		logic [3:0]  scale_decade;
	} meter_answer_t;

	logic clk;
	logic arst_n;
	brm_in_if  in_ch();
	brm_out_if out_ch();
	brm_cfg_if cfg();

	bandwidth_rate_meter_autorange_core #(.CHANNELS(NCH), .TOP_SCALE_INDEX(TOP_IDX)) u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg));

	// predictor state
	logic [39:0] rate_mem [2*NCH];
	logic [43:0] in_sum, out_sum;
	logic [6:0]  range_idx;
	int          countdown;
	logic [23:0] window_us;
	logic [5:0]  shrink_cnt;

	meter_item_t   pending_words[$];
	meter_answer_t expected_answers[$];
	int            errors = 0;
	longint unsigned cycles = 0;
	int            hold_off = 0;
	bit            long_hold_req = 0;
	bit            cfg_req = 0;
	logic          cfg_idx_req;
	logic [23:0]   cfg_data_req;
	int            gap_cnt = 0;

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	function automatic meter_answer_t predict_answer(meter_item_t w);
		meter_answer_t a;
		logic [39:0] old_r, new_r;
		logic [127:0] target, delta, full_cap, lo_side, hi_side, limit;
		logic [43:0] total;
		int slot;
		a = '0;
		a.kind = w.command;
		if (w.command == brm_pkg::CMD_SAMPLE) begin
			if (w.channel < NCH) begin
				slot = w.direction * NCH + w.channel;
				old_r = rate_mem[slot];
				new_r = old_r;
				if (w.elapsed_us != 0) begin
					target = ((128'(w.byte_count) * 1000) << 16) / w.elapsed_us;
					if (target > 128'(brm_pkg::RATE_MAX)) target = 128'(brm_pkg::RATE_MAX);
					if (w.elapsed_us >= window_us) new_r = target[39:0];
					else if (target >= 128'(old_r)) begin
						delta = ((target - old_r) * w.elapsed_us) / window_us;
						new_r = old_r + delta[39:0];
					end else begin
						delta = ((128'(old_r) - target) * w.elapsed_us) / window_us;
						new_r = old_r - delta[39:0];
					end
					rate_mem[slot] = new_r;
					if (w.direction == 1'b0) in_sum = in_sum - old_r + new_r;
					else out_sum = out_sum - old_r + new_r;
				end
				a.stream_rate = new_r;
			end
		end else begin
			total = (in_sum > out_sum) ? in_sum : out_sum;
			full_cap = 128'(total);
			lo_side = full_cap * 1220703125;
			hi_side = (full_cap << 1) * 1220703125;
			limit = (128'(range_idx % 9 + 2) * 128'(pow10_tab(range_idx / 9))) << 23;
			if (hi_side < limit) begin
				if (countdown > -1) countdown--;
				if (countdown < 0 && range_idx > 0) range_idx--;
			end else begin
				countdown = shrink_cnt;
				if (lo_side > limit && range_idx < TOP_IDX) range_idx++;
			end
		end
		a.total_in = in_sum;
		a.total_out = out_sum;
		a.scale_index = range_idx;
		a.scale_steps = 4'(range_idx % 9 + 2);
		a.scale_decade = 4'(range_idx / 9);
		return a;
	endfunction

	function automatic longint unsigned pow10_tab(int d);
		longint unsigned p;
		p = 1;
		if (d > 14) d = 14;
		for (int i = 0; i < d; i++) p = p * 10;
		return p;
	endfunction

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.command <= 1'b0;
			in_ch.channel <= '0;
			in_ch.direction <= 1'b0;
			in_ch.byte_count <= '0;
			in_ch.elapsed_us <= '0;
			gap_cnt <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				expected_answers.push_back(predict_answer({in_ch.command, in_ch.channel,
					in_ch.direction, in_ch.byte_count, in_ch.elapsed_us}));
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_cnt > 0) begin
					gap_cnt <= gap_cnt - 1;
					in_ch.valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					meter_item_t w;
					w = pending_words.pop_front();
					in_ch.valid <= 1'b1;
					{in_ch.command, in_ch.channel, in_ch.direction, in_ch.byte_count,
						in_ch.elapsed_us} <= w;
					gap_cnt <= rand_gap();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// configuration writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.valid <= 1'b0;
			cfg.index <= brm_pkg::CFG_WINDOW;
			cfg.data <= '0;
		end else if (cfg.valid) begin
			if (cfg.ready) begin
				cfg.valid <= 1'b0;
				if (cfg.index == brm_pkg::CFG_WINDOW) window_us = cfg.data;
				else shrink_cnt = cfg.data[5:0];
				cfg_req = 0;
			end
		end else if (cfg_req) begin
			cfg.valid <= 1'b1;
			cfg.index <= cfg_idx_req;
			cfg.data <= cfg_data_req;
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_off <= 0;
		end else begin
			cycles <= cycles + 1;
			if (out_ch.valid && out_ch.ready) begin
				meter_answer_t got, exp_a;
				got = {out_ch.kind, out_ch.stream_rate, out_ch.total_in, out_ch.total_out,
					out_ch.scale_index, out_ch.scale_steps, out_ch.scale_decade};
				if (expected_answers.size() == 0) begin
					$display("%0t: unexpected word %h", $time, got);
					errors++;
				end else begin
					exp_a = expected_answers.pop_front();
					if (got.kind != exp_a.kind)
						$display("%0t: kind exp %0d got %0d", $time, exp_a.kind, got.kind);
					if (got.stream_rate != exp_a.stream_rate)
						$display("%0t: stream_rate exp %0d got %0d", $time,
							exp_a.stream_rate, got.stream_rate);
					if (got.total_in != exp_a.total_in)
						$display("%0t: total_in exp %0d got %0d", $time,
							exp_a.total_in, got.total_in);
					if (got.total_out != exp_a.total_out)
						$display("%0t: total_out exp %0d got %0d", $time,
							exp_a.total_out, got.total_out);
					if (got.scale_index != exp_a.scale_index)
						$display("%0t: scale_index exp %0d got %0d", $time,
							exp_a.scale_index, got.scale_index);
					if (got.scale_steps != exp_a.scale_steps)
						$display("%0t: scale_steps exp %0d got %0d", $time,
							exp_a.scale_steps, got.scale_steps);
					if (got.scale_decade != exp_a.scale_decade)
						$display("%0t: scale_decade exp %0d got %0d", $time,
							exp_a.scale_decade, got.scale_decade);
					if (got != exp_a) errors++;
				end
			end
			if (long_hold_req) begin
				hold_off <= 3000;
				long_hold_req = 0;
				out_ch.ready <= 1'b0;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				hold_off <= rand_gap();
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
			if (cycles > CYCLE_LIMIT) begin
				$display("FAIL bandwidth_rate_meter_autorange_core");
				$finish;
			end
		end
	end

	function automatic meter_item_t make_sample(logic [2:0] ch, logic d, logic [23:0] b,
		logic [23:0] e);
		meter_item_t w;
		w.command = brm_pkg::CMD_SAMPLE;
		w.channel = ch;
		w.direction = d;
		w.byte_count = b;
		w.elapsed_us = e;
		return w;
	endfunction

	function automatic meter_item_t make_frame();
		meter_item_t w;
		w = '0;
		w.command = brm_pkg::CMD_FRAME;
		w.channel = $urandom;
		w.direction = $urandom;
		w.byte_count = $urandom;
		w.elapsed_us = $urandom;
		return w;
	endfunction

	function automatic meter_item_t random_word();
		meter_item_t w;
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) return make_frame();
		w = make_sample($urandom_range(0, 7) < 6 ? $urandom_range(0, NCH - 1)
			: $urandom_range(0, 7), $urandom, 0, 0);
		case ($urandom_range(0, 3))
			0: w.byte_count = $urandom;
			1: w.byte_count = $urandom_range(0, 5000);
			2: w.byte_count = $urandom_range(0, 200);
			default: w.byte_count = 24'hFFFFFF - $urandom_range(0, 3);
		endcase
		case ($urandom_range(0, 4))
			0: w.elapsed_us = $urandom;
			1: w.elapsed_us = $urandom_range(1, 100);
			2: w.elapsed_us = $urandom_range(1, 20000);
			3: w.elapsed_us = $urandom_range(0, 1) ? 24'd0 : 24'hFFFFFF;
			default: w.elapsed_us = $urandom_range(100, 2000000);
		endcase
		return w;
	endfunction

	task automatic drain();
		while (pending_words.size() > 0 || in_ch.valid || expected_answers.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [23:0] val);
		cfg_idx_req = idx;
		cfg_data_req = val;
		cfg_req = 1;
		while (cfg_req) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) pending_words.push_back(random_word());
		drain();
	endtask

	initial begin
		for (int i = 0; i < 2*NCH; i++) rate_mem[i] = '0;
		in_sum = '0;
		out_sum = '0;
		range_idx = brm_pkg::RESET_INDEX < TOP_IDX ? brm_pkg::RESET_INDEX : 7'(TOP_IDX);
		countdown = 0;
		window_us = brm_pkg::RESET_WINDOW;
		shrink_cnt = brm_pkg::RESET_SHRINK;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, ignored samples, frames around the scale
		pending_words.push_back(make_frame());
		pending_words.push_back(make_sample(0, 0, 24'hFFFFFF, 24'd1));
		pending_words.push_back(make_sample(2, 1, 24'hFFFFFF, 24'hFFFFFF));
		pending_words.push_back(make_sample(1, 0, 24'd1000, 24'd0));
		pending_words.push_back(make_sample(7, 1, 24'd5, 24'd10));
		pending_words.push_back(make_sample(3, 0, 24'd5, 24'd10));
		pending_words.push_back(make_sample(0, 0, 24'd0, 24'd500));
		pending_words.push_back(make_sample(1, 1, 24'd1, 24'd1000000));
		for (int i = 0; i < 6; i++) pending_words.push_back(make_frame());
		pending_words.push_back(make_sample(0, 0, 24'd0, 24'hFFFFFF));
		pending_words.push_back(make_sample(2, 1, 24'd0, 24'hFFFFFF));
		for (int i = 0; i < 4; i++) pending_words.push_back(make_frame());
		drain();

		write_reg(brm_pkg::CFG_SHRINK, 24'd0);
		for (int i = 0; i < 60; i++) pending_words.push_back(make_frame());
		drain();
		write_reg(brm_pkg::CFG_WINDOW, 24'd1);
		write_reg(brm_pkg::CFG_SHRINK, 24'd63);
		random_phase(150);
		write_reg(brm_pkg::CFG_WINDOW, 24'hFFFFFF);
		// long receiver stall while items keep coming
		long_hold_req = 1;
		random_phase(150);
		write_reg(brm_pkg::CFG_WINDOW, 24'd0);
		write_reg(brm_pkg::CFG_SHRINK, 24'd2);
		random_phase(100);
		write_reg(brm_pkg::CFG_WINDOW, 24'd1000);
		write_reg(brm_pkg::CFG_SHRINK, 24'd5);
		random_phase(150);
		write_reg(brm_pkg::CFG_WINDOW, 24'd50000);
		random_phase(150);

		if (errors == 0) $display("PASS bandwidth_rate_meter_autorange_core");
		else $display("FAIL bandwidth_rate_meter_autorange_core");
		$finish;
	end
endmodule
